// ===== src/fpa_pkg.sv =====
// Shared types and constants for the fit placement allocator.
// Holds the request and result payload structs, the policy, command and register codes and the scan token control struct.
// No dependencies.
package fpa_pkg;

    // Default sizing of the allocation table
    localparam int MAX_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    // Fixed field widths of the channels and the register port
    localparam int ENTRY_W    = 4;
    localparam int VALUE_W    = 16;
    localparam int MODE_W     = 2;
    localparam int ACTIVE_W   = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Request commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 1'b1;

    // Placement policies
    typedef enum logic [MODE_W-1:0] {
        POL_FIRST = 2'd0,
        POL_NEXT  = 2'd1,
        POL_BEST  = 2'd2,
        POL_WORST = 2'd3
    } t_policy;

    // Control part of the scan token handed from cell to cell
    typedef struct packed {
        logic valid;     // token present in this stage
        logic found;     // a candidate has been chosen so far
        logic found_hi;  // next fit: a candidate at or beyond the start entry
    } t_tok_ctl;

    // Input request
    typedef struct packed {
        logic               cmd;
        logic [ENTRY_W-1:0] entry_index;
        logic [VALUE_W-1:0] size_value;
        logic               batch_end;
    } t_in_req;

    // Result
    typedef struct packed {
        logic               allocated;
        logic [ENTRY_W-1:0] block_index;
        logic [VALUE_W-1:0] size_before;
        logic [VALUE_W-1:0] size_after;
        logic               last_flag;
    } t_out_res;

endpackage

// ===== src/fpa_cell.sv =====
// One cell of the allocator chain: holds one table entry and refines the scan token.
// The token moves one cell per clock; the cell's entry is written through a shared write port.
// Depends on fpa_pkg.
module fpa_cell #(
    parameter int  MAX_BLOCKS = 16,
    parameter int  SIZE_BITS  = 16,
    parameter int  CELL_IDX   = 0,
    localparam int IDX_W      = $clog2(MAX_BLOCKS),
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Broadcast settings
    input  fpa_pkg::t_policy     i_mode,
    input  logic [CNT_W-1:0]     i_active_n,
    input  logic [IDX_W-1:0]     i_start,
    // Table write port
    input  logic                 i_wr_en,
    input  logic [IDX_W-1:0]     i_wr_idx,
    input  logic [SIZE_BITS-1:0] i_wr_data,
    // Token from the previous cell
    input  fpa_pkg::t_tok_ctl    i_ctl,
    input  logic [SIZE_BITS-1:0] i_req,
    input  logic [IDX_W-1:0]     i_pick,
    input  logic [SIZE_BITS-1:0] i_size,
    input  logic [IDX_W-1:0]     i_pick_hi,
    input  logic [SIZE_BITS-1:0] i_size_hi,
    // Token to the next cell
    output fpa_pkg::t_tok_ctl    o_ctl,
    output logic [SIZE_BITS-1:0] o_req,
    output logic [IDX_W-1:0]     o_pick,
    output logic [SIZE_BITS-1:0] o_size,
    output logic [IDX_W-1:0]     o_pick_hi,
    output logic [SIZE_BITS-1:0] o_size_hi
);
    import fpa_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);

    logic [SIZE_BITS-1:0] r_size;
    t_tok_ctl             r_ctl;
    logic [SIZE_BITS-1:0] r_req;
    logic [IDX_W-1:0]     r_pick;
    logic [SIZE_BITS-1:0] r_sz;
    logic [IDX_W-1:0]     r_pick_hi;
    logic [SIZE_BITS-1:0] r_sz_hi;

    t_tok_ctl n_ctl;
    logic     w_live;
    logic     w_fit;
    logic     w_better;
    logic     w_take;
    logic     w_take_hi;

    // Fit test and candidate comparison; same request, so a size compare orders the leftovers
    always_comb begin
        w_live = (MY_CNT < i_active_n);
        w_fit  = i_ctl.valid && w_live && (i_req <= r_size);
        case (i_mode)
            POL_BEST:  w_better = !i_ctl.found || (r_size < i_size);
            POL_WORST: w_better = !i_ctl.found || (r_size > i_size);
            default:   w_better = !i_ctl.found;
        endcase
        w_take    = w_fit && w_better;
        w_take_hi = w_fit && (i_mode == POL_NEXT) && !i_ctl.found_hi && (MY_IDX >= i_start);

        n_ctl.valid    = i_ctl.valid;
        n_ctl.found    = i_ctl.found || w_take;
        n_ctl.found_hi = i_ctl.found_hi || w_take_hi;
    end

    // Token control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    // Token data and the stored entry
    always_ff @(posedge i_clk) begin
        r_req     <= i_req;
        r_pick    <= w_take ? MY_IDX : i_pick;
        r_sz      <= w_take ? r_size : i_size;
        r_pick_hi <= w_take_hi ? MY_IDX : i_pick_hi;
        r_sz_hi   <= w_take_hi ? r_size : i_size_hi;
        if (i_wr_en && (i_wr_idx == MY_IDX)) begin
            r_size <= i_wr_data;
        end
    end

    assign o_ctl     = r_ctl;
    assign o_req     = r_req;
    assign o_pick    = r_pick;
    assign o_size    = r_sz;
    assign o_pick_hi = r_pick_hi;
    assign o_size_hi = r_sz_hi;

endmodule

// ===== src/fit_placement_allocator_unit.sv =====
// Fit placement allocator: a table of free block sizes with first, next, best and worst fit.
// One request is in work at a time. A load passes from the finish state to the result register;
// an allocate first walks its search token along the row of MAX_BLOCKS cells, one table entry
// per clock, and is then resolved and written back. The next request is accepted once the result
// has entered the result register. A finished result waits in the output register while the
// next request is taken; if that one finishes while the output is still stalled, the input stalls
// until the output register frees. There is no clearing pass after reset: table entries are
// undefined until loaded. The user must make register writes only while the block is idle;
// the block itself does not enforce this.
// Depends on fpa_pkg and fpa_cell.
module fit_placement_allocator_unit #(
    parameter int MAX_BLOCKS = fpa_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpa_pkg::SIZE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Register write port
    input  logic                                i_cfg_we,
    input  logic [fpa_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fpa_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // Request channel
    input  logic                                i_in_valid,
    input  fpa_pkg::t_in_req                    i_in_data,
    output logic                                o_in_stall,
    // Result channel
    output logic                                o_out_valid,
    output fpa_pkg::t_out_res                   o_out_data,
    input  logic                                i_out_stall
);
    import fpa_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    localparam logic [ACTIVE_W-1:0]  ACTIVE_RST = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    // Registers
    t_state               r_state, n_state;
    t_policy              r_mode, n_mode;
    logic [ACTIVE_W-1:0]  r_active, n_active;
    logic [IDX_W-1:0]     r_next, n_next;
    logic                 r_last, n_last;
    logic                 r_fin_wr, n_fin_wr;
    logic                 r_fin_next, n_fin_next;
    logic [IDX_W-1:0]     r_fin_wr_idx, n_fin_wr_idx;
    logic [SIZE_BITS-1:0] r_fin_wr_data, n_fin_wr_data;
    t_out_res             r_fin, n_fin;
    logic                 r_out_valid, n_out_valid;
    t_out_res             r_out, n_out;

    // Token row
    t_tok_ctl             w_ctl     [0:MAX_BLOCKS];
    logic [SIZE_BITS-1:0] w_req     [0:MAX_BLOCKS];
    logic [IDX_W-1:0]     w_pick    [0:MAX_BLOCKS];
    logic [SIZE_BITS-1:0] w_size    [0:MAX_BLOCKS];
    logic [IDX_W-1:0]     w_pick_hi [0:MAX_BLOCKS];
    logic [SIZE_BITS-1:0] w_size_hi [0:MAX_BLOCKS];

    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_wr_en;
    logic [SIZE_BITS-1:0] w_val;
    logic [CNT_W-1:0]     w_n;
    logic [IDX_W-1:0]     w_start;
    logic                 w_in_range;
    logic                 w_use_hi;
    logic                 w_found;
    logic [IDX_W-1:0]     w_sel_pick;
    logic [SIZE_BITS-1:0] w_sel_size;
    logic [SIZE_BITS-1:0] w_after;

    // Handshake and common terms
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_wr_en    = (r_state == ST_FIN) && w_out_free && r_fin_wr;
    assign w_val      = SIZE_BITS'(i_in_data.size_value);
    assign w_in_range = (32'(i_in_data.entry_index) < MAX_BLOCKS);

    // Active entry count, saturated at the table depth
    always_comb begin
        if (32'(r_active) > MAX_BLOCKS) begin
            w_n = CNT_W'(MAX_BLOCKS);
        end else begin
            w_n = CNT_W'(r_active);
        end
    end

    // Next-fit start entry; a stale start falls back to entry 0. Steady for the whole scan.
    assign w_start = (CNT_W'(r_next) < w_n) ? r_next : '0;

    // Token injection at the head of the row
    always_comb begin
        w_ctl[0].valid    = w_accept && (i_in_data.cmd != CMD_LOAD);
        w_ctl[0].found    = 1'b0;
        w_ctl[0].found_hi = 1'b0;
        w_req[0]          = w_val;
        w_pick[0]         = '0;
        w_size[0]         = '0;
        w_pick_hi[0]      = '0;
        w_size_hi[0]      = '0;
    end

    // Row of cells
    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        fpa_cell #(
            .MAX_BLOCKS (MAX_BLOCKS),
            .SIZE_BITS  (SIZE_BITS),
            .CELL_IDX   (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_mode     (r_mode),
            .i_active_n (w_n),
            .i_start    (w_start),
            .i_wr_en    (w_wr_en),
            .i_wr_idx   (r_fin_wr_idx),
            .i_wr_data  (r_fin_wr_data),
            .i_ctl      (w_ctl[g]),
            .i_req      (w_req[g]),
            .i_pick     (w_pick[g]),
            .i_size     (w_size[g]),
            .i_pick_hi  (w_pick_hi[g]),
            .i_size_hi  (w_size_hi[g]),
            .o_ctl      (w_ctl[g+1]),
            .o_req      (w_req[g+1]),
            .o_pick     (w_pick[g+1]),
            .o_size     (w_size[g+1]),
            .o_pick_hi  (w_pick_hi[g+1]),
            .o_size_hi  (w_size_hi[g+1])
        );
    end

    // Resolve the token at the tail: next fit prefers a hit at or past the start entry
    always_comb begin
        w_use_hi   = (r_mode == POL_NEXT) && w_ctl[MAX_BLOCKS].found_hi;
        w_found    = w_use_hi || w_ctl[MAX_BLOCKS].found;
        w_sel_pick = w_use_hi ? w_pick_hi[MAX_BLOCKS] : w_pick[MAX_BLOCKS];
        w_sel_size = w_use_hi ? w_size_hi[MAX_BLOCKS] : w_size[MAX_BLOCKS];
        w_after    = w_sel_size - w_req[MAX_BLOCKS];
    end

    // Sequencer, registers and result register
    always_comb begin
        n_state       = r_state;
        n_mode        = r_mode;
        n_active      = r_active;
        n_next        = r_next;
        n_last        = r_last;
        n_fin_wr      = r_fin_wr;
        n_fin_next    = r_fin_next;
        n_fin_wr_idx  = r_fin_wr_idx;
        n_fin_wr_data = r_fin_wr_data;
        n_fin         = r_fin;
        n_out_valid   = r_out_valid;
        n_out         = r_out;

        // Result taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // Register writes
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_POLICY: n_mode   = t_policy'(i_cfg_data[MODE_W-1:0]);
                REG_ACTIVE: n_active = i_cfg_data[ACTIVE_W-1:0];
                default:    n_mode   = r_mode;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.cmd == CMD_LOAD) begin
                        n_fin.allocated   = 1'b0;
                        n_fin.block_index = i_in_data.entry_index;
                        n_fin.size_before = '0;
                        n_fin.size_after  = w_in_range ? VALUE_W'(w_val) : '0;
                        n_fin.last_flag   = i_in_data.batch_end;
                        n_fin_wr          = w_in_range;
                        n_fin_next        = 1'b0;
                        n_fin_wr_idx      = IDX_W'(32'(i_in_data.entry_index));
                        n_fin_wr_data     = w_val;
                        n_state           = ST_FIN;
                    end else begin
                        n_last  = i_in_data.batch_end;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (w_ctl[MAX_BLOCKS].valid) begin
                    n_fin.allocated   = w_found;
                    n_fin.block_index = w_found ? ENTRY_W'(w_sel_pick) : '0;
                    n_fin.size_before = w_found ? VALUE_W'(w_sel_size) : '0;
                    n_fin.size_after  = w_found ? VALUE_W'(w_after) : '0;
                    n_fin.last_flag   = r_last;
                    n_fin_wr          = w_found;
                    n_fin_next        = w_found && (r_mode == POL_NEXT);
                    n_fin_wr_idx      = w_sel_pick;
                    n_fin_wr_data     = w_after;
                    n_state           = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_fin;
                    if (r_fin_next) begin
                        n_next = r_fin_wr_idx;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= POL_FIRST;
            r_active    <= ACTIVE_RST;
            r_next      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_active    <= n_active;
            r_next      <= n_next;
            r_out_valid <= n_out_valid;
        end
        r_last        <= n_last;
        r_fin_wr      <= n_fin_wr;
        r_fin_next    <= n_fin_next;
        r_fin_wr_idx  <= n_fin_wr_idx;
        r_fin_wr_data <= n_fin_wr_data;
        r_fin         <= n_fin;
        r_out         <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== dv/fit_placement_allocator_unit_tb.sv =====
// Testbench for fit_placement_allocator_unit: directed and random load/allocate requests.
// A scoreboard class predicts each result from its own copy of the size table and registers.
// Depends on fpa_pkg and the allocator RTL.
module fit_placement_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fpa_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int MAX_BLOCKS     = MAX_BLOCKS_DEF;
    localparam int SETTLE_CYCLES  = MAX_BLOCKS + 4;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_REQUESTS = 50;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_kind;

    // Sizes loaded at the start; every entry is written before any allocate
    localparam logic [VALUE_W-1:0] INITIAL_SIZES [16] = '{
        16'd100, 16'd0, 16'hFFFF, 16'd50, 16'd300, 16'd50, 16'd1000, 16'd7,
        16'd2000, 16'd3, 16'd40, 16'd41, 16'd500, 16'd8000, 16'd12, 16'd60
    };

    // Active-count setting of each random phase, extremes included
    localparam logic [ACTIVE_W-1:0] PHASE_ACTIVE [16] = '{
        5'd16, 5'd1, 5'd16, 5'd0, 5'd31, 5'd16, 5'd5, 5'd16,
        5'd2, 5'd16, 5'd17, 5'd9, 5'd16, 5'd1, 5'd16, 5'd12
    };

    // Allocation predictor and result checker
    class t_alloc_scoreboard;
        logic [VALUE_W-1:0]  free_size [MAX_BLOCKS];
        int                  next_start;
        t_policy             policy;
        logic [ACTIVE_W-1:0] active_blocks;
        t_out_res            expected_q[$];
        int                  errors;

        function void reset_state();
            foreach (free_size[i]) free_size[i] = '0;
            next_start    = 0;
            policy        = POL_FIRST;
            active_blocks = 5'd16;
            errors        = 0;
            expected_q.delete();
        endfunction

        function void set_config(t_policy pol, logic [ACTIVE_W-1:0] active);
            policy        = pol;
            active_blocks = active;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Work out the result of one accepted request and update the table
        function void note_request(t_in_req req);
            t_out_res           res;
            int                 n;
            int                 start;
            int                 j;
            int                 pick;
            bit                 found;
            logic [VALUE_W-1:0] left;
            logic [VALUE_W-1:0] best_left;

            res           = '0;
            res.last_flag = req.batch_end;
            if (req.cmd == CMD_LOAD) begin
                res.block_index = req.entry_index;
                free_size[req.entry_index] = req.size_value;
                res.size_after = req.size_value;
            end else begin
                n         = (active_blocks > MAX_BLOCKS) ? MAX_BLOCKS : active_blocks;
                found     = 1'b0;
                pick      = 0;
                best_left = '0;
                if (policy == POL_NEXT) begin
                    // circular scan from the last pick; stale start falls back to entry 0
                    start = (next_start < n) ? next_start : 0;
                    for (int i = 0; i < n && !found; i++) begin
                        j = (start + i) % n;
                        if (req.size_value <= free_size[j]) begin
                            found = 1'b1;
                            pick  = j;
                        end
                    end
                end else begin
                    // strict comparisons keep the lowest index on ties
                    for (int i = 0; i < n; i++) begin
                        if (req.size_value <= free_size[i]) begin
                            left = free_size[i] - req.size_value;
                            if (!found ||
                                (policy == POL_BEST  && left < best_left) ||
                                (policy == POL_WORST && left > best_left)) begin
                                found     = 1'b1;
                                pick      = i;
                                best_left = left;
                            end
                        end
                    end
                end
                if (found) begin
                    res.allocated   = 1'b1;
                    res.block_index = pick[ENTRY_W-1:0];
                    res.size_before = free_size[pick];
                    res.size_after  = free_size[pick] - req.size_value;
                    free_size[pick] = res.size_after;
                    if (policy == POL_NEXT) next_start = pick;
                end
            end
            expected_q.push_back(res);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t ns: %s", $time, msg);
            errors++;
        endtask

        task check_field(string name, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        // Compare one accepted result with the oldest expectation
        task check_result(t_out_res got);
            t_out_res want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0h", got));
            end else begin
                want = expected_q.pop_front();
                check_field("allocated",   got.allocated,   want.allocated);
                check_field("block_index", got.block_index, want.block_index);
                check_field("size_before", got.size_before, want.size_before);
                check_field("size_after",  got.size_after,  want.size_after);
                check_field("last_flag",   got.last_flag,   want.last_flag);
            end
        endtask
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    t_in_req               i_in_data   = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_res              o_out_data;
    logic                  i_out_stall = 1'b0;

    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int hold_reqs     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    t_alloc_scoreboard sb;

    fit_placement_allocator_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Result side stall: random, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_seen != hold_reqs) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES - 1;
            hold_seen   <= hold_reqs;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            sb.check_result(o_out_data);
    end

    // Watchdog on cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TIMEOUT after %0d quiet cycles", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic t_in_req make_req(logic cmd, int idx, int size, logic last);
        t_in_req req;
        req.cmd         = cmd;
        req.entry_index = idx[ENTRY_W-1:0];
        req.size_value  = size[VALUE_W-1:0];
        req.batch_end   = last;
        return req;
    endfunction

    // Offer one request after a random gap; entered and left at a falling edge
    task automatic send_request(t_in_req req);
        int gap;
        gap = 0;
        while ($urandom_range(99) < in_idle_pct) gap++;
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        sb.note_request(req);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every result is back, plus the pipeline depth
    task automatic drain_and_pause();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Both registers, written back to back while idle
    task automatic set_mode(t_policy pol, logic [ACTIVE_W-1:0] active);
        drain_and_pause();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_POLICY;
        i_cfg_data  <= CFG_DATA_W'(pol);
        @(negedge i_clk);
        i_cfg_index <= REG_ACTIVE;
        i_cfg_data  <= active;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_config(pol, active);
        @(negedge i_clk);
    endtask

    task automatic set_idle(t_idle_kind kind);
        case (kind)
            IDLE_NONE: begin
                in_idle_pct   = 0;
                out_stall_pct <= 0;
            end
            IDLE_SENDER: begin
                in_idle_pct   = 61;
                out_stall_pct <= 0;
            end
            IDLE_RECEIVER: begin
                in_idle_pct   = 0;
                out_stall_pct <= 61;
            end
            default: begin
                in_idle_pct   = 31;
                out_stall_pct <= 31;
            end
        endcase
    endtask

    // Random phase: reloads mixed with allocations of mostly small sizes
    task automatic run_phase(t_policy pol, logic [ACTIVE_W-1:0] active,
                             t_idle_kind kind, bit pressure);
        t_in_req req;
        int      pick;
        set_mode(pol, active);
        set_idle(kind);
        if (pressure) hold_reqs <= hold_reqs + 1;
        repeat (PHASE_REQUESTS) begin
            req.cmd         = ($urandom_range(99) < 30) ? CMD_LOAD : CMD_ALLOC;
            req.entry_index = ENTRY_W'($urandom_range(15));
            req.batch_end   = 1'($urandom_range(1));
            pick            = int'($urandom_range(9));
            if (req.cmd == CMD_LOAD)
                req.size_value = (pick < 2) ? 16'hFFFF :
                                 (pick < 3) ? 16'd0 :
                                 (pick < 6) ? VALUE_W'($urandom_range(4095)) :
                                              VALUE_W'($urandom_range(65535));
            else
                req.size_value = (pick < 1) ? 16'd0 :
                                 (pick < 2) ? 16'hFFFF :
                                 (pick < 6) ? VALUE_W'($urandom_range(15)) :
                                 (pick < 9) ? VALUE_W'($urandom_range(1023)) :
                                              VALUE_W'($urandom_range(65535));
            send_request(req);
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();

        // Synchronous reset
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: fill the whole table, then first fit extremes
        set_mode(POL_FIRST, 5'd16);
        for (int i = 0; i < 16; i++)
            send_request(make_req(CMD_LOAD, i, INITIAL_SIZES[i], i == 15));
        send_request(make_req(CMD_ALLOC, 0, 0, 1'b0));        // zero request
        send_request(make_req(CMD_ALLOC, 0, 16'hFFFF, 1'b0)); // exact fit, leaves zero
        send_request(make_req(CMD_ALLOC, 0, 16'hFFFF, 1'b1)); // nothing fits

        // Best and worst fit, with ties on equal leftovers
        set_mode(POL_BEST, 5'd16);
        send_request(make_req(CMD_ALLOC, 0, 40, 1'b0));
        send_request(make_req(CMD_ALLOC, 0, 50, 1'b1));
        set_mode(POL_WORST, 5'd16);
        send_request(make_req(CMD_ALLOC, 0, 10, 1'b1));

        // Next fit, then shrink the table under the saved start entry
        set_mode(POL_NEXT, 5'd16);
        send_request(make_req(CMD_ALLOC, 0, 900, 1'b0));
        send_request(make_req(CMD_ALLOC, 0, 5, 1'b0));
        set_mode(POL_NEXT, 5'd2);
        send_request(make_req(CMD_ALLOC, 0, 1, 1'b1));

        // Empty table, then an active count past the table size
        set_mode(POL_FIRST, 5'd0);
        send_request(make_req(CMD_ALLOC, 0, 0, 1'b1));
        set_mode(POL_WORST, 5'd31);
        send_request(make_req(CMD_ALLOC, 0, 1, 1'b1));

        // Random phases: every policy under every idling pattern
        for (int k = 0; k < 16; k++)
            run_phase(t_policy'(k % 4), PHASE_ACTIVE[k], t_idle_kind'(k / 4), k == 1);

        drain_and_pause();
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/fpa_pkg.sv
src/fpa_cell.sv
src/fit_placement_allocator_unit.sv
dv/fit_placement_allocator_unit_tb.sv
